>>> src/rotation_matrix_to_quaternion_defines.svh
// Assertion macros used by the checker file.
`ifndef ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_DEFINES_SVH

// Checks the consequent in the same cycle as the antecedent.
`define RMQ_ASSERT_SAME(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define RMQ_ASSERT_NEXT(lbl, clock, reset, ante, cons, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/rmq_pkg.sv
package rmq_pkg;

  localparam int FRAC_BITS_DEFAULT = 14;
  localparam int DIGITS_PER_STAGE = 4;
  localparam int LANES = 4;
  localparam int SIGN_W = 3;

  localparam logic [1:0] LANE_W = 2'd0;
  localparam logic [1:0] LANE_X = 2'd1;
  localparam logic [1:0] LANE_Y = 2'd2;
  localparam logic [1:0] LANE_Z = 2'd3;

  localparam logic [1:0] NEG_X = 2'd0;
  localparam logic [1:0] NEG_Y = 2'd1;
  localparam logic [1:0] NEG_Z = 2'd2;

  localparam logic [14:0] MAG_MAX = 15'h7fff;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
  } mat_t;

  typedef struct packed {
    logic [14:0]        qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } quat_t;

endpackage

>>> src/rmq_sqrt_stage.sv
module rmq_sqrt_stage #(
  parameter int QW = 16,
  parameter int RW = 32,
  parameter int NDIG = rmq_pkg::DIGITS_PER_STAGE
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [rmq_pkg::LANES-1:0][RW-1:0]       in_rad,
  input  logic [rmq_pkg::LANES-1:0][QW:0]         in_rem,
  input  logic [rmq_pkg::LANES-1:0][QW-1:0]       in_root,
  input  logic [rmq_pkg::SIGN_W-1:0]              in_neg,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [rmq_pkg::LANES-1:0][RW-1:0]       out_rad,
  output logic [rmq_pkg::LANES-1:0][QW:0]         out_rem,
  output logic [rmq_pkg::LANES-1:0][QW-1:0]       out_root,
  output logic [rmq_pkg::SIGN_W-1:0]              out_neg
);

  logic [rmq_pkg::LANES-1:0][RW-1:0] rad_next;
  logic [rmq_pkg::LANES-1:0][QW:0]   rem_next;
  logic [rmq_pkg::LANES-1:0][QW-1:0] root_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    logic [RW-1:0] rad_v;
    logic [QW:0]   rem_v;
    logic [QW-1:0] root_v;
    logic [QW+2:0] rs;
    logic [QW+2:0] tr;
    rad_next = '0;
    rem_next = '0;
    root_next = '0;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      rad_v = in_rad[l];
      rem_v = in_rem[l];
      root_v = in_root[l];
      for (int d = 0; d < NDIG; d++) begin
        rs = {rem_v, rad_v[RW-1 -: 2]};
        tr = {1'b0, root_v, 2'b01};
        if (rs >= tr) begin
          rem_v = (QW+1)'(rs - tr);
          root_v = {root_v[QW-2:0], 1'b1};
        end else begin
          rem_v = rs[QW:0];
          root_v = {root_v[QW-2:0], 1'b0};
        end
        rad_v = rad_v << 2;
      end
      rad_next[l] = rad_v;
      rem_next[l] = rem_v;
      root_next[l] = root_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_rad <= rad_next;
      out_rem <= rem_next;
      out_root <= root_next;
      out_neg <= in_neg;
    end
  end

endmodule

>>> src/rotation_matrix_to_quaternion.sv
// QW is the root width set by FRAC_BITS (16 bits at FRAC_BITS = 14). Throughput: one
// matrix per cycle while quat_ready does not stall the output. The rate is set by
// the square-root pipeline, which resolves up to four root digits of all four lanes
// in each stage. Reset clears every stage's valid bit and empties the pipeline;
// payload registers are not reset.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           mat_valid,
  output logic           mat_ready,
  input  rmq_pkg::mat_t  mat,
  output logic           quat_valid,
  input  logic           quat_ready,
  output rmq_pkg::quat_t quat
);

  localparam int SW = ((FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18) + 1;
  localparam int VW = SW - 1 + FRAC_BITS;
  localparam int RW = VW + VW % 2;
  localparam int QW = RW / 2;
  localparam int MW = QW - 1;
  localparam int DPS = rmq_pkg::DIGITS_PER_STAGE;
  localparam int NS = (QW + DPS - 1) / DPS;
  localparam logic signed [SW-1:0] ONE = SW'(1) << FRAC_BITS;

  logic                                    st_valid [NS+1];
  logic                                    st_ready [NS+1];
  logic [rmq_pkg::LANES-1:0][RW-1:0]       st_rad   [NS+1];
  logic [rmq_pkg::LANES-1:0][QW:0]         st_rem   [NS+1];
  logic [rmq_pkg::LANES-1:0][QW-1:0]       st_root  [NS+1];
  logic [rmq_pkg::SIGN_W-1:0]              st_neg   [NS+1];

  logic signed [SW-1:0] e00;
  logic signed [SW-1:0] e11;
  logic signed [SW-1:0] e22;
  logic signed [SW-1:0] t_sum [rmq_pkg::LANES];
  logic [rmq_pkg::LANES-1:0][RW-1:0] rad0_next;
  logic [rmq_pkg::SIGN_W-1:0]        neg0_next;
  logic [16:0] dx;
  logic [16:0] dy;
  logic [16:0] dz;

  logic [rmq_pkg::LANES-1:0][14:0] sat;
  rmq_pkg::quat_t quat_next;

  assign mat_ready = !st_valid[0] || st_ready[0];

  always_comb begin
    e00 = SW'(mat.r00);
    e11 = SW'(mat.r11);
    e22 = SW'(mat.r22);
    t_sum[rmq_pkg::LANE_W] = ONE + e00 + e11 + e22;
    t_sum[rmq_pkg::LANE_X] = ONE + e00 - e11 - e22;
    t_sum[rmq_pkg::LANE_Y] = ONE - e00 + e11 - e22;
    t_sum[rmq_pkg::LANE_Z] = ONE - e00 - e11 + e22;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      if (t_sum[l][SW-1]) begin
        rad0_next[l] = '0;
      end else begin
        rad0_next[l] = RW'(t_sum[l][SW-2:0]) << FRAC_BITS;
      end
    end
    dx = {mat.r21[15], mat.r21} - {mat.r12[15], mat.r12};
    dy = {mat.r02[15], mat.r02} - {mat.r20[15], mat.r20};
    dz = {mat.r10[15], mat.r10} - {mat.r01[15], mat.r01};
    neg0_next[rmq_pkg::NEG_X] = dx[16];
    neg0_next[rmq_pkg::NEG_Y] = dy[16];
    neg0_next[rmq_pkg::NEG_Z] = dz[16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (mat_ready) begin
      st_valid[0] <= mat_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_valid && mat_ready) begin
      st_rad[0] <= rad0_next;
      st_rem[0] <= '0;
      st_root[0] <= '0;
      st_neg[0] <= neg0_next;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_root
    localparam int LEFT = QW - s * DPS;
    localparam int NDIG = (LEFT < DPS) ? LEFT : DPS;

    rmq_sqrt_stage #(
      .QW   (QW),
      .RW   (RW),
      .NDIG (NDIG)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[s]),
      .in_ready  (st_ready[s]),
      .in_rad    (st_rad[s]),
      .in_rem    (st_rem[s]),
      .in_root   (st_root[s]),
      .in_neg    (st_neg[s]),
      .out_valid (st_valid[s+1]),
      .out_ready (st_ready[s+1]),
      .out_rad   (st_rad[s+1]),
      .out_rem   (st_rem[s+1]),
      .out_root  (st_root[s+1]),
      .out_neg   (st_neg[s+1])
    );
  end

  assign st_ready[NS] = !quat_valid || quat_ready;

  always_comb begin
    logic [MW+15:0] mag_ext;
    logic [15:0]    mx;
    logic [15:0]    my;
    logic [15:0]    mz;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      mag_ext = (MW+16)'(st_root[NS][l][QW-1:1]);
      if (mag_ext > (MW+16)'(rmq_pkg::MAG_MAX)) begin
        sat[l] = rmq_pkg::MAG_MAX;
      end else begin
        sat[l] = mag_ext[14:0];
      end
    end
    mx = {1'b0, sat[rmq_pkg::LANE_X]};
    my = {1'b0, sat[rmq_pkg::LANE_Y]};
    mz = {1'b0, sat[rmq_pkg::LANE_Z]};
    quat_next.qw = sat[rmq_pkg::LANE_W];
    quat_next.qx = st_neg[NS][rmq_pkg::NEG_X] ? 16'd0 - mx : mx;
    quat_next.qy = st_neg[NS][rmq_pkg::NEG_Y] ? 16'd0 - my : my;
    quat_next.qz = st_neg[NS][rmq_pkg::NEG_Z] ? 16'd0 - mz : mz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_valid <= 1'b0;
    end else if (st_ready[NS]) begin
      quat_valid <= st_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (st_valid[NS] && st_ready[NS]) begin
      quat <= quat_next;
    end
  end

endmodule

>>> src/rmq_checker.sv
`include "rotation_matrix_to_quaternion_defines.svh"

module rmq_checker (
  input logic           clk,
  input logic           rst,
  input logic           mat_valid,
  input logic           mat_ready,
  input rmq_pkg::mat_t  mat,
  input logic           quat_valid,
  input logic           quat_ready,
  input rmq_pkg::quat_t quat
);

  // A stalled result transfer keeps its valid and its payload.
  `RMQ_ASSERT_NEXT(a_hold, clk, rst, quat_valid && !quat_ready, quat_valid && $stable(quat), "result changed while stalled")

  // Magnitudes saturate below 32768, so no signed part can reach the most negative code.
  `RMQ_ASSERT_SAME(a_range, clk, rst, quat_valid, quat.qx != 16'h8000 && quat.qy != 16'h8000 && quat.qz != 16'h8000, "signed part out of range")

  // A pipeline drained at the output never holds back a new transfer.
  `RMQ_ASSERT_SAME(a_flow, clk, rst, quat_ready, mat_ready, "input stalled while output is ready")

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
